// ===== sv/prfl_pkg.sv =====
// Shared constants, register indexes and command types for the page replacement unit.
package prfl_pkg;

  // Table geometry
  localparam int NUM_PAGES  = 32;
  localparam int NUM_FRAMES = 16;
  localparam int PAGE_BYTES = 256;

  localparam int PAGE_W     = $clog2(NUM_PAGES);
  localparam int FRAME_W    = $clog2(NUM_FRAMES);
  localparam int CNT_FR_W   = $clog2(NUM_FRAMES + 1);
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int PRE_CNT    = (NUM_FRAMES < NUM_PAGES) ? NUM_FRAMES : NUM_PAGES;

  // Field widths
  localparam int ADDR_W   = 13;
  localparam int FCNT_W   = 16;
  localparam int CFG_IDX_W = 2;

  // Stream widths (whole bytes)
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_FIELD_W = 1 + PAGE_W + FRAME_W + 1 + PAGE_W + 1 + FCNT_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_USE_LRU   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PREPAGING = 2'd1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic cfg_wr;   // configuration transaction: write register, reinitialize tables
    logic load;     // input transaction: capture page and access kind
    logic look;     // table lookup, pick frame and victim
    logic update;   // apply table and order list changes, load result
  } cmd_t;

endpackage

// ===== sv/prfl_ctrl.sv =====
// Controller state machine: handshakes and sequencing of one access.
module prfl_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  output prfl_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_UPD,
    S_SEND
  } state_t;

  state_t state_r;
  logic   in_tready_r;
  logic   out_tvalid_r;

  // Drive commands from the current state; a configuration write goes first
  always_comb begin
    cmd.cfg_wr = cfg_valid && in_tready_r;
    cmd.load   = in_tvalid && in_tready_r && !cfg_valid;
    cmd.look   = (state_r == S_LOOK);
    cmd.update = (state_r == S_UPD);
  end

  // Hold state and handshake outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      in_tready_r  <= 1'b1;
      out_tvalid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (cmd.load) begin
            state_r     <= S_LOOK;
            in_tready_r <= 1'b0;
          end
        end
        S_LOOK: begin
          state_r <= S_UPD;
        end
        S_UPD: begin
          state_r      <= S_SEND;
          out_tvalid_r <= 1'b1;
        end
        S_SEND: begin
          if (out_tready) begin
            state_r      <= S_IDLE;
            out_tvalid_r <= 1'b0;
            in_tready_r  <= 1'b1;
          end
        end
        default: begin
          state_r      <= S_IDLE;
          in_tready_r  <= 1'b1;
          out_tvalid_r <= 1'b0;
        end
      endcase
    end
  end

  assign in_tready  = in_tready_r && !cfg_valid;
  assign cfg_ready  = in_tready_r;
  assign out_tvalid = out_tvalid_r;

endmodule

// ===== sv/prfl_dp.sv =====
// Datapath: page table, frame owners, replacement order list, fault counter, result register.
module prfl_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  prfl_pkg::cmd_t                       cmd,
  input  logic [prfl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic                                 cfg_data,
  input  logic [prfl_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic                                 in_tuser,
  output logic [prfl_pkg::OUT_TDATA_W-1:0]     out_tdata
);

  localparam int NP  = prfl_pkg::NUM_PAGES;
  localparam int NF  = prfl_pkg::NUM_FRAMES;
  localparam int PW  = prfl_pkg::PAGE_W;
  localparam int FW  = prfl_pkg::FRAME_W;
  localparam int CW  = prfl_pkg::CNT_FR_W;
  localparam int KW  = prfl_pkg::FCNT_W;

  // Configuration
  logic use_lru_r, prepaging_r;
  logic use_lru_nxt, prepaging_nxt;
  logic cfg_known;

  // Tables
  logic [NP-1:0]  valid_r, valid_nxt;
  logic [NP-1:0]  dirty_r, dirty_nxt;
  logic [FW-1:0]  map_r   [NP];
  logic [PW-1:0]  owner_r [NF];
  logic [FW-1:0]  list_r  [NF];
  logic [FW-1:0]  list_nxt[NF];
  logic [CW-1:0]  len_r, len_nxt;
  logic [CW-1:0]  fiu_r, fiu_nxt;
  logic [KW-1:0]  fcnt_r, fcnt_nxt;

  // Current access and lookup results
  logic [PW-1:0]  page_r;
  logic           write_r;
  logic           hit_r, evict_r;
  logic [FW-1:0]  frame_r;
  logic [PW-1:0]  evp_r;
  logic [prfl_pkg::OUT_TDATA_W-1:0] out_r;

  // Lookup stage logic
  logic           hit_c, evict_c;
  logic [FW-1:0]  frame_c;

  // Update stage logic
  logic           found;
  logic [FW-1:0]  pos;
  logic           rm_en, push_en;
  logic [CW-1:0]  len_a;
  logic           wb_c;

  // Pick configuration values after a write; other indexes are ignored
  always_comb begin
    use_lru_nxt   = use_lru_r;
    prepaging_nxt = prepaging_r;
    cfg_known     = (cfg_index == prfl_pkg::REG_USE_LRU) ||
                    (cfg_index == prfl_pkg::REG_PREPAGING);
    if (cfg_index == prfl_pkg::REG_USE_LRU) begin
      use_lru_nxt = cfg_data;
    end
    if (cfg_index == prfl_pkg::REG_PREPAGING) begin
      prepaging_nxt = cfg_data;
    end
  end

  // Look up the page, pick the frame that serves it
  always_comb begin
    hit_c   = valid_r[page_r];
    evict_c = !hit_c && (prepaging_r || (fiu_r >= CW'(NF))) && (len_r != '0);
    if (hit_c) begin
      frame_c = map_r[page_r];
    end else if (evict_c) begin
      frame_c = list_r[0];
    end else begin
      frame_c = fiu_r[FW-1:0];
    end
  end

  // Find the frame's place in the order list
  always_comb begin
    found = 1'b0;
    pos   = '0;
    for (int i = 0; i < NF; i++) begin
      if (!found && (CW'(i) < len_r) && (list_r[i] == frame_r)) begin
        found = 1'b1;
        pos   = FW'(i);
      end
    end
  end

  // Remove an entry and push the frame at the recent end
  always_comb begin
    rm_en   = hit_r ? (use_lru_r && found) : evict_r;
    push_en = !hit_r || use_lru_r;
    len_a   = len_r - CW'(rm_en);
    for (int i = 0; i < NF; i++) begin
      if (rm_en && (FW'(i) >= (hit_r ? pos : '0)) && (i < NF - 1)) begin
        list_nxt[i] = list_r[(i < NF - 1) ? i + 1 : i];
      end else begin
        list_nxt[i] = list_r[i];
      end
    end
    len_nxt = len_a;
    if (push_en && (len_a < CW'(NF))) begin
      list_nxt[len_a[FW-1:0]] = frame_r;
      len_nxt = len_a + CW'(1);
    end
  end

  // Valid, dirty, counters for the update stage
  always_comb begin
    wb_c      = dirty_r[evp_r];
    valid_nxt = valid_r;
    dirty_nxt = dirty_r;
    fiu_nxt   = fiu_r;
    fcnt_nxt  = fcnt_r;
    if (!hit_r) begin
      if (fcnt_r != '1) begin
        fcnt_nxt = fcnt_r + KW'(1);
      end
      if (evict_r) begin
        valid_nxt[evp_r] = 1'b0;
        dirty_nxt[evp_r] = 1'b0;
      end else if (fiu_r < CW'(NF)) begin
        fiu_nxt = fiu_r + CW'(1);
      end
      valid_nxt[page_r] = 1'b1;
    end
    if (write_r) begin
      dirty_nxt[page_r] = 1'b1;
    end
  end

  // Control state: configuration, valid and dirty marks, counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_lru_r   <= 1'b0;
      prepaging_r <= 1'b0;
      valid_r     <= '0;
      dirty_r     <= '0;
      len_r       <= '0;
      fiu_r       <= '0;
      fcnt_r      <= '0;
    end else if (cmd.cfg_wr && cfg_known) begin
      use_lru_r   <= use_lru_nxt;
      prepaging_r <= prepaging_nxt;
      dirty_r     <= '0;
      fcnt_r      <= '0;
      for (int i = 0; i < NP; i++) begin
        valid_r[i] <= prepaging_nxt && (i < prfl_pkg::PRE_CNT);
      end
      len_r <= prepaging_nxt ? CW'(prfl_pkg::PRE_CNT) : '0;
      fiu_r <= prepaging_nxt ? CW'(prfl_pkg::PRE_CNT) : '0;
    end else if (cmd.update) begin
      valid_r <= valid_nxt;
      dirty_r <= dirty_nxt;
      len_r   <= len_nxt;
      fiu_r   <= fiu_nxt;
      fcnt_r  <= fcnt_nxt;
    end
  end

  // Payload tables: preload identity; list written per update, map and owner per fault
  always_ff @(posedge clk) begin
    if (cmd.cfg_wr && cfg_known) begin
      if (prepaging_nxt) begin
        for (int i = 0; i < prfl_pkg::PRE_CNT; i++) begin
          map_r[i]   <= FW'(i);
          owner_r[i] <= PW'(i);
          list_r[i]  <= FW'(i);
        end
      end
    end else if (cmd.update) begin
      list_r <= list_nxt;
      if (!hit_r) begin
        map_r[page_r]    <= frame_r;
        owner_r[frame_r] <= page_r;
      end
    end
  end

  // Capture the access, hold lookup results, load the result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      page_r  <= in_tdata[prfl_pkg::PAGE_SHIFT +: PW];
      write_r <= in_tuser;
    end
    if (cmd.look) begin
      hit_r   <= hit_c;
      evict_r <= evict_c;
      frame_r <= frame_c;
      evp_r   <= owner_r[list_r[0]];
    end
    if (cmd.update) begin
      out_r <= prfl_pkg::OUT_TDATA_W'({
        fcnt_nxt,
        evict_r && wb_c,
        evict_r ? evp_r : PW'(0),
        evict_r,
        frame_r,
        page_r,
        !hit_r
      });
    end
  end

  assign out_tdata = out_r;

endmodule

// ===== sv/page_replacement_fifo_lru_top.sv =====
// Top level of the page replacement unit: controller and datapath.
//
// Each access (13-bit address, read or write) is mapped to page address[12:8] and looked
// up in a 32-entry page table backed by 16 frames. A hit keeps the mapping; with use_lru
// set, its frame moves to the recent end of the order list. A miss counts a fault
// (saturating at 65535), then takes the next free frame or evicts the front of the order
// list (oldest loaded in FIFO mode, least recently used in LRU mode), reporting the evicted
// page and a write-back when that page was dirty. A write access marks its page dirty.
// Writing either configuration register reinitializes all tables; writes to other indexes
// are ignored. With prepaging set, pages 0 to 15 start mapped to frames 0 to 15. One
// access is handled at a time: after the input transaction the controller steps through
// the table lookup, the order list and table update and the result valid states, and
// the next input transaction is taken the cycle after the output transaction. Handling
// one access at a time is set by the read-modify-write of the order list that the next
// access depends on. Configuration writes are taken only while no access is in progress
// and go ahead of a waiting access.
module page_replacement_fifo_lru_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [prfl_pkg::IN_TDATA_W-1:0]      in_tdata,   // [12:0] address, [15:13] zero
  input  logic                                 in_tuser,   // [0] action (1 write)
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [0] fault, [5:1] page, [9:6] frame_slot, [10] evicted, [15:11] evicted_page,
  // [16] write_back, [32:17] fault_total, [39:33] zero
  output logic [prfl_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [prfl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic                                 cfg_data
);

  prfl_pkg::cmd_t cmd;

  prfl_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cmd        (cmd)
  );

  prfl_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tdata (out_tdata)
  );

endmodule

// ===== tb/tb_page_replacement_fifo_lru_top.sv =====
// Page replacement unit testbench: directed and random accesses checked against a predictor.
`timescale 1ns / 100ps

module tb_page_replacement_fifo_lru_top;

  // Unassigned register indexes, writes to them must leave the tables alone
  localparam logic [prfl_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [prfl_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  localparam int RANDOM_ACCESSES = 1800;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int DRAIN_CYCLES    = 20;
  localparam int MAX_REPORTS     = 40;

  typedef enum logic {ITEM_ACCESS, ITEM_CFG} item_kind_t;

  typedef struct {
    item_kind_t                     kind;
    logic [prfl_pkg::ADDR_W-1:0]    addr;
    logic                           wr;
    logic [prfl_pkg::CFG_IDX_W-1:0] idx;
    logic                           val;
  } plan_item_t;

  // Result fields, lowest bit last
  typedef struct packed {
    logic [prfl_pkg::FCNT_W-1:0]  fault_total;
    logic                         write_back;
    logic [prfl_pkg::PAGE_W-1:0]  evicted_page;
    logic                         evicted;
    logic [prfl_pkg::FRAME_W-1:0] frame_slot;
    logic [prfl_pkg::PAGE_W-1:0]  page;
    logic                         fault;
  } translation_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [prfl_pkg::IN_TDATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [prfl_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [prfl_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic cfg_data = 1'b0;

  page_replacement_fifo_lru_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Stimulus plan and predicted translations
  plan_item_t   access_plan[$];
  translation_t predicted_translations[$];

  // Predictor state
  logic                         mode_lru;
  logic                         mode_prepage;
  logic                         pg_valid [prfl_pkg::NUM_PAGES];
  logic [prfl_pkg::FRAME_W-1:0] pg_frame [prfl_pkg::NUM_PAGES];
  logic                         pg_dirty [prfl_pkg::NUM_PAGES];
  logic [prfl_pkg::PAGE_W-1:0]  fr_owner [prfl_pkg::NUM_FRAMES];
  int                           frame_order[$];
  int                           frames_used;
  logic [prfl_pkg::FCNT_W-1:0]  fault_cnt;

  int regular_len;
  int n_sent;
  int n_cfg;
  int n_hits;
  int n_evicts;
  int n_wbacks;
  int n_results;
  int n_bad;
  int idle_phase;
  int stall_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Clear the tables, optionally preloading the first frames
  function automatic void reload_tables();
    for (int i = 0; i < prfl_pkg::NUM_PAGES; i++) begin
      pg_valid[i] = 1'b0;
      pg_frame[i] = '0;
      pg_dirty[i] = 1'b0;
    end
    for (int i = 0; i < prfl_pkg::NUM_FRAMES; i++) fr_owner[i] = '0;
    frame_order.delete();
    frames_used = 0;
    fault_cnt   = '0;
    if (mode_prepage) begin
      for (int i = 0; i < prfl_pkg::PRE_CNT; i++) begin
        pg_valid[i] = 1'b1;
        pg_frame[i] = prfl_pkg::FRAME_W'(i);
        fr_owner[i] = prfl_pkg::PAGE_W'(i);
        frame_order.push_back(i);
      end
      frames_used = prfl_pkg::PRE_CNT;
    end
  endfunction

  function automatic void apply_register(logic [prfl_pkg::CFG_IDX_W-1:0] idx, logic val);
    if (idx == prfl_pkg::REG_USE_LRU) begin
      mode_lru = val;
      reload_tables();
    end else if (idx == prfl_pkg::REG_PREPAGING) begin
      mode_prepage = val;
      reload_tables();
    end
  endfunction

  // Translate one access and update the tables
  function automatic translation_t predict_translation(logic [prfl_pkg::ADDR_W-1:0] addr,
                                                       logic wr);
    translation_t r;
    int pg;
    int fr;
    int ev;
    int hit_pos;
    r       = '0;
    hit_pos = -1;
    pg      = int'((addr >> prfl_pkg::PAGE_SHIFT) % prfl_pkg::NUM_PAGES);
    r.page  = prfl_pkg::PAGE_W'(pg);
    if (pg_valid[pg]) begin
      n_hits++;
      fr = int'(pg_frame[pg]);
      if (mode_lru) begin
        foreach (frame_order[k]) begin
          if (frame_order[k] == fr) begin
            hit_pos = k;
            break;
          end
        end
        if (hit_pos >= 0) frame_order.delete(hit_pos);
        if (frame_order.size() < prfl_pkg::NUM_FRAMES) frame_order.push_back(fr);
      end
    end else begin
      r.fault = 1'b1;
      if (fault_cnt != '1) fault_cnt++;
      if ((mode_prepage || frames_used >= prfl_pkg::NUM_FRAMES) && frame_order.size() > 0) begin
        fr             = frame_order.pop_front();
        ev             = int'(fr_owner[fr]);
        r.evicted      = 1'b1;
        r.evicted_page = prfl_pkg::PAGE_W'(ev);
        r.write_back   = pg_dirty[ev];
        pg_valid[ev]   = 1'b0;
        pg_dirty[ev]   = 1'b0;
        n_evicts++;
        if (r.write_back) n_wbacks++;
      end else begin
        fr = frames_used % prfl_pkg::NUM_FRAMES;
        if (frames_used < prfl_pkg::NUM_FRAMES) frames_used++;
      end
      pg_valid[pg] = 1'b1;
      pg_frame[pg] = prfl_pkg::FRAME_W'(fr);
      fr_owner[fr] = prfl_pkg::PAGE_W'(pg);
      if (frame_order.size() < prfl_pkg::NUM_FRAMES) frame_order.push_back(fr);
    end
    if (wr) pg_dirty[pg] = 1'b1;
    r.frame_slot  = prfl_pkg::FRAME_W'(fr);
    r.fault_total = fault_cnt;
    return r;
  endfunction

  function automatic void plan_access(int pg, logic wr);
    plan_item_t it;
    it.kind = ITEM_ACCESS;
    it.addr = prfl_pkg::ADDR_W'((pg << prfl_pkg::PAGE_SHIFT) |
                                $urandom_range(0, prfl_pkg::PAGE_BYTES - 1));
    it.wr   = wr;
    it.idx  = '0;
    it.val  = 1'b0;
    access_plan.push_back(it);
  endfunction

  function automatic void plan_raw_access(logic [prfl_pkg::ADDR_W-1:0] addr, logic wr);
    plan_item_t it;
    it.kind = ITEM_ACCESS;
    it.addr = addr;
    it.wr   = wr;
    it.idx  = '0;
    it.val  = 1'b0;
    access_plan.push_back(it);
  endfunction

  function automatic void plan_write(logic [prfl_pkg::CFG_IDX_W-1:0] idx, logic val);
    plan_item_t it;
    it.kind = ITEM_CFG;
    it.addr = '0;
    it.wr   = 1'b0;
    it.idx  = idx;
    it.val  = val;
    access_plan.push_back(it);
  endfunction

  task automatic check_field(string name, int want, int got, inout logic bad);
    if (want != got) begin
      bad = 1'b1;
      if (n_bad < MAX_REPORTS)
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Driver: present planned transactions, predict each accepted access
  always @(posedge clk) begin
    logic nxt_in;
    logic nxt_cfg;
    plan_item_t head;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      cfg_valid <= 1'b0;
      mode_lru     = 1'b0;
      mode_prepage = 1'b0;
      reload_tables();
    end else begin
      nxt_in  = in_tvalid;
      nxt_cfg = cfg_valid;
      if (in_tvalid && in_tready) begin
        predicted_translations.push_back(
          predict_translation(in_tdata[prfl_pkg::ADDR_W-1:0], in_tuser));
        n_sent++;
        nxt_in = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        apply_register(cfg_index, cfg_data);
        n_cfg++;
        nxt_cfg = 1'b0;
      end
      idle_phase = (n_sent < regular_len / 3) ? 0 : (n_sent < 2 * regular_len / 3) ? 1 : 2;
      if (!nxt_in && !nxt_cfg && access_plan.size() > 0) begin
        head = access_plan[0];
        if (head.kind == ITEM_CFG) begin
          // Hold register writes until every translation is back
          if (predicted_translations.size() == 0 && !(in_tvalid && in_tready)) begin
            cfg_index <= head.idx;
            cfg_data  <= head.val;
            nxt_cfg = 1'b1;
            void'(access_plan.pop_front());
          end
        end else if ($urandom_range(0, 99) >= (idle_phase == 0 ? 34 : idle_phase == 1 ? 45 : 0)) begin
          in_tdata <= {{(prfl_pkg::IN_TDATA_W - prfl_pkg::ADDR_W){1'b0}}, head.addr};
          in_tuser <= head.wr;
          nxt_in = 1'b1;
          void'(access_plan.pop_front());
        end
      end
      in_tvalid <= nxt_in;
      cfg_valid <= nxt_cfg;
    end
  end

  // Monitor: stall at random, compare each result with the oldest prediction
  always @(posedge clk) begin
    translation_t want;
    translation_t got;
    logic bad;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        n_results++;
        got = translation_t'(out_tdata[prfl_pkg::OUT_FIELD_W-1:0]);
        if (predicted_translations.size() == 0) begin
          if (n_bad < MAX_REPORTS)
            $display("%0t: unexpected result: expected none, actual 0x%0h", $time, out_tdata);
          n_bad++;
        end else begin
          want = predicted_translations.pop_front();
          bad  = 1'b0;
          check_field("fault", want.fault, got.fault, bad);
          check_field("page", want.page, got.page, bad);
          check_field("frame_slot", want.frame_slot, got.frame_slot, bad);
          check_field("evicted", want.evicted, got.evicted, bad);
          check_field("evicted_page", want.evicted_page, got.evicted_page, bad);
          check_field("write_back", want.write_back, got.write_back, bad);
          check_field("fault_total", want.fault_total, got.fault_total, bad);
          check_field("padding", 0,
                      int'(out_tdata[prfl_pkg::OUT_TDATA_W-1:prfl_pkg::OUT_FIELD_W]), bad);
          if (bad) n_bad++;
        end
      end
      out_tready <= ($urandom_range(0, 99) >= (idle_phase == 0 ? 45 : idle_phase == 1 ? 34 : 0));
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    int ws_base;
    int ws_size;
    int blk_len;
    int blk;
    int pg;
    regular_len  = RANDOM_ACCESSES;

    // Directed: FIFO demand paging from an empty table
    plan_raw_access('0, 1'b0);
    plan_raw_access('1, 1'b1);
    plan_raw_access(13'h00FF, 1'b0);
    plan_raw_access(13'h1F00, 1'b0);
    for (int p = 2; p < 16; p++) plan_access(p, p[0]);
    // Table full: evict a clean page, then the dirty top page
    plan_access(16, 1'b0);
    plan_access(17, 1'b0);
    // LRU with preloaded frames
    plan_write(prfl_pkg::REG_USE_LRU, 1'b1);
    plan_write(prfl_pkg::REG_PREPAGING, 1'b1);
    plan_access(3, 1'b1);
    plan_access(20, 1'b0);
    // Spare indexes must not reinitialize anything
    plan_write(REG_SPARE_2, 1'b1);
    plan_write(REG_SPARE_3, 1'b0);
    plan_access(0, 1'b0);
    plan_access(3, 1'b0);

    // Random: blocks of accesses around a moving working set
    blk = 0;
    while (access_plan.size() < RANDOM_ACCESSES + 30) begin
      if (blk < 4) begin
        plan_write(prfl_pkg::REG_USE_LRU, blk[0] ^ blk[1]);
        plan_write(prfl_pkg::REG_PREPAGING, blk[1]);
      end else begin
        plan_write(prfl_pkg::CFG_IDX_W'($urandom_range(0, 3)), $urandom_range(0, 1) == 1);
        if ($urandom_range(0, 3) == 0)
          plan_write(prfl_pkg::CFG_IDX_W'($urandom_range(0, 3)), $urandom_range(0, 1) == 1);
      end
      ws_base = $urandom_range(0, prfl_pkg::NUM_PAGES - 1);
      ws_size = $urandom_range(3, 28);
      blk_len = $urandom_range(40, 160);
      for (int k = 0; k < blk_len; k++) begin
        if ($urandom_range(0, 99) < 15) begin
          plan_raw_access(prfl_pkg::ADDR_W'($urandom_range(0, (1 << prfl_pkg::ADDR_W) - 1)),
                          $urandom_range(0, 1) == 1);
        end else begin
          pg = (ws_base + $urandom_range(0, ws_size - 1)) % prfl_pkg::NUM_PAGES;
          plan_access(pg, $urandom_range(0, 2) == 0);
        end
      end
      blk++;
    end
    foreach (access_plan[k]) if (access_plan[k].kind == ITEM_ACCESS) regular_len = k;

    // Back to FIFO demand paging for a short closing run
    plan_write(prfl_pkg::REG_USE_LRU, 1'b0);
    plan_write(prfl_pkg::REG_PREPAGING, 1'b0);
    for (int k = 0; k < 40; k++) plan_access($urandom_range(0, 12), $urandom_range(0, 1) == 1);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (access_plan.size() != 0 || in_tvalid || cfg_valid ||
           predicted_translations.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb: %0d accesses, %0d results, %0d register writes, %0d hits, %0d evictions",
             n_sent, n_results, n_cfg, n_hits, n_evicts);
    $display("tb: FIFO and LRU, demand and prepaged, %0d write-backs; %0d bad results",
             n_wbacks, n_bad);
    if (n_bad == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/prfl_pkg.sv
sv/prfl_ctrl.sv
sv/prfl_dp.sv
sv/page_replacement_fifo_lru_top.sv
tb/tb_page_replacement_fifo_lru_top.sv
